[rtl/core/hpx_pkg.sv]
// Shared types and constants for the HEALPix nested-to-ring converter.
`timescale 1ns / 1ps

package hpx_pkg;

	localparam int NSIDE_W  = 14;
	localparam int IDX_W    = 31;
	localparam int N_W      = 30;
	localparam int SQ_W     = 2 * NSIDE_W;
	localparam int DIV_W    = SQ_W + 4;
	localparam int QUOT_W   = 4;
	localparam int RING_W   = 15;
	localparam int LON_W    = 17;
	localparam int STATUS_W = 2;

	localparam logic [QUOT_W-1:0]   FACE_COUNT  = 4'd12;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_FACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_RING = 2'd2;

	// One request as it moves through the face divider.
	typedef struct packed {
		logic              valid;
		logic              bad;
		logic [QUOT_W-1:0] quot;
		logic [N_W-1:0]    rem;
	} div_s_t;

endpackage

[rtl/core/hpx_div_step.sv]
// One restoring step of the face divider: decides one quotient bit.
`timescale 1ns / 1ps

module hpx_div_step
	import hpx_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SQ_W-1:0]   sq,
	input  div_s_t            din,
	output div_s_t            dout
);

	logic [DIV_W-1:0] divisor;
	logic             take;
	logic [N_W-1:0]   rem_next;
	logic [QUOT_W-1:0] quot_next;

	always_comb begin
		divisor   = DIV_W'(sq) << SHIFT;
		take      = DIV_W'(din.rem) >= divisor;
		rem_next  = take ? (din.rem - divisor[N_W-1:0]) : din.rem;
		quot_next = din.quot;
		quot_next[SHIFT] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.bad   <= din.bad;
			dout.quot  <= quot_next;
			dout.rem   <= rem_next;
		end
	end

endmodule

[rtl/core/hpx_ring.sv]
// Back end: de-interleave, ring and shift, longitude and result register.
`timescale 1ns / 1ps

module hpx_ring
	import hpx_pkg::*;
#(
	parameter int BIT_PAIRS = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [NSIDE_W-1:0]         nside,
	input  logic [NSIDE_W+1:0]         ns3,
	input  div_s_t                     din,
	output logic                       done,
	output logic [RING_W-1:0]          ring_index,
	output logic signed [LON_W-1:0]    longitude,
	output logic [STATUS_W-1:0]        status
);

	localparam int PW    = (2 * BIT_PAIRS > N_W) ? 2 * BIT_PAIRS : N_W;
	localparam int XW    = BIT_PAIRS + 1;
	localparam int BIG_W = (NSIDE_W + 3 > XW) ? NSIDE_W + 3 : XW;
	localparam int SUM_W = BIG_W + 2;

	// Stage 6: split the offset, form the ring number.
	logic [PW-1:0]        p_ext;
	logic [BIT_PAIRS-1:0] x, y;
	logic [XW-1:0]        xpy;
	logic [XW-1:0]        xmy;
	logic [1:0]           frow;
	logic [NSIDE_W+1:0]   base;
	logic [SUM_W-1:0]     ring_c;
	logic                 face_bad;

	always_comb begin
		p_ext = PW'(din.rem);
		for (int i = 0; i < BIT_PAIRS; i++) begin
			x[i] = p_ext[2*i];
			y[i] = p_ext[2*i+1];
		end
		xpy  = XW'(x) + XW'(y);
		xmy  = XW'(x) - XW'(y);
		frow = din.quot[3:2];
		case (frow)
			2'd0:    base = {1'b0, nside, 1'b0};
			2'd1:    base = ns3;
			default: base = {nside, 2'b00};
		endcase
		ring_c   = SUM_W'(base) - SUM_W'(xpy) - SUM_W'(1);
		face_bad = din.bad || (din.quot >= FACE_COUNT);
	end

	logic                   valid_s6;
	logic                   bad_s6;
	logic signed [SUM_W-1:0] ring_s6;
	logic signed [XW-1:0]   xmy_s6;
	logic [2:0]             f2_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= din.valid;
		end
	end

	// F2 = 2*(f mod 4) + 1 - (row mod 2) packs into three bits.
	always_ff @(posedge clk) begin
		bad_s6  <= face_bad;
		ring_s6 <= $signed(ring_c);
		xmy_s6  <= $signed(xmy);
		f2_s6   <= {din.quot[1:0], ~frow[0]};
	end

	// Stage 7: range check, shift and longitude numerator.
	logic signed [SUM_W-1:0] ns_s, ns3_s, ns4_s;
	logic                    ring_bad;
	logic                    polar;
	logic                    s_bit;
	logic [NSIDE_W+2:0]      f2ns;
	logic [SUM_W-1:0]        lon_c;
	logic [STATUS_W-1:0]     status_c;

	always_comb begin
		ns_s     = $signed(SUM_W'(nside));
		ns3_s    = $signed(SUM_W'(ns3));
		ns4_s    = $signed(SUM_W'({nside, 2'b00}));
		ring_bad = (ring_s6 < $signed(SUM_W'(1))) || (ring_s6 >= ns4_s);
		polar    = (ring_s6 < ns_s) || (ring_s6 > ns3_s);
		s_bit    = polar ? 1'b1 : ~(ring_s6[0] ^ nside[0]);
		f2ns     = (NSIDE_W+3)'(f2_s6) * (NSIDE_W+3)'(nside);
		lon_c    = SUM_W'(f2ns) + SUM_W'(xmy_s6) + SUM_W'(s_bit);
		if (bad_s6) begin
			status_c = ST_BAD_FACE;
		end else if (ring_bad) begin
			status_c = ST_BAD_RING;
		end else begin
			status_c = ST_OK;
		end
	end

	logic                valid_s7;
	logic [STATUS_W-1:0] status_s7;
	logic [SUM_W-1:0]    ring_s7;
	logic [SUM_W-1:0]    lon_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		status_s7 <= status_c;
		ring_s7   <= ring_s6;
		lon_s7    <= lon_c;
	end

	// Stage 8: halve with truncation toward zero, clear fields on error.
	logic [SUM_W-1:0] lon_adj;
	logic [SUM_W-1:0] lon_half;

	always_comb begin
		lon_adj  = lon_s7 + SUM_W'(lon_s7[SUM_W-1]);
		lon_half = $unsigned($signed(lon_adj) >>> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		status <= status_s7;
		if (status_s7 == ST_OK) begin
			ring_index <= ring_s7[RING_W-1:0];
			longitude  <= $signed(lon_half[LON_W-1:0]);
		end else begin
			ring_index <= '0;
			longitude  <= '0;
		end
	end

endmodule

[rtl/core/healpix_nested_to_ring.sv]
// Top level of the HEALPix nested-to-ring index converter.
`timescale 1ns / 1ps

// Converts a nested pixel index into its ring number and longitude at the
// resolution held in the nside register.
// Input: a request is taken at each rising edge where start is high and busy
// is low. busy stays low, so a new index may be presented every cycle.
// Output: done is high for one cycle with ring_index, longitude and status;
// the receiver cannot stall, and results come out in request order.
// Configuration: cfg_data is written into nside when cfg_valid and cfg_ready
// are high; cfg_ready is always high. Write only while no request is in flight.
// Throughput is one request per cycle. The pipeline is the input stage, the
// four-step face divider (one quotient bit per stage) and three back-end
// stages for ring, shift and longitude.
// Reset clears all stage valid bits and sets nside to 1.
module healpix_nested_to_ring
	import hpx_pkg::*;
#(
	parameter int BIT_PAIRS = 13
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [IDX_W-1:0]  nested_index,
	output logic                     done,
	output logic [RING_W-1:0]        ring_index,
	output logic signed [LON_W-1:0]  longitude,
	output logic [STATUS_W-1:0]      status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [NSIDE_W-1:0]       cfg_data
);

	logic [NSIDE_W-1:0] nside_q;
	logic [SQ_W-1:0]    sq_q;
	logic [NSIDE_W+1:0] ns3_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Square and triple of nside are kept alongside it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nside_q <= NSIDE_W'(1);
			sq_q    <= SQ_W'(1);
			ns3_q   <= (NSIDE_W+2)'(3);
		end else if (cfg_valid && cfg_ready) begin
			nside_q <= cfg_data;
			sq_q    <= SQ_W'(cfg_data) * SQ_W'(cfg_data);
			ns3_q   <= (NSIDE_W+2)'({cfg_data, 1'b0}) + (NSIDE_W+2)'(cfg_data);
		end
	end

	logic           accept;
	logic [N_W-1:0] n_in;
	logic           over;

	always_comb begin
		accept = start && !busy;
		n_in   = nested_index[N_W-1:0];
		// A face of sixteen or more cannot come out of the four-bit divider.
		over   = DIV_W'(n_in) >= {sq_q, 4'b0000};
	end

	div_s_t div_s1;
	div_s_t stage [0:QUOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s1 <= '0;
		end else begin
			div_s1.valid <= accept;
			div_s1.bad   <= nested_index[IDX_W-1] || over;
			div_s1.quot  <= '0;
			div_s1.rem   <= n_in;
		end
	end

	assign stage[0] = div_s1;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_div
		hpx_div_step #(
			.SHIFT(QUOT_W - 1 - k)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.sq     (sq_q),
			.din    (stage[k]),
			.dout   (stage[k+1])
		);
	end

	hpx_ring #(
		.BIT_PAIRS(BIT_PAIRS)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.nside      (nside_q),
		.ns3        (ns3_q),
		.din        (stage[QUOT_W]),
		.done       (done),
		.ring_index (ring_index),
		.longitude  (longitude),
		.status     (status)
	);

endmodule
